// File: design/eqrs_pkg.sv
package eqrs_pkg;

    // Port and register geometry
    localparam int IN_W      = 24;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_W     = 26;

    // Filter geometry
    localparam int LP_TAPS   = 12;
    localparam int LP_MID    = 6;
    localparam int HP_TAPS   = 32;
    localparam int HP_AW     = 5;
    localparam int HP_DELAY  = 15;
    localparam int WIN_LEN   = 32;
    localparam int WIN_AW    = 5;

    // Datapath widths
    localparam int LP_W      = 27;
    localparam int BAND_W    = 28;
    localparam int DSUM_W    = 31;
    localparam int DERIV_W   = 28;
    localparam int SQ_W      = 32;
    localparam int TOTAL_W   = 38;
    localparam int INTEG_W   = 27;
    localparam int SSUM_W    = 30;
    localparam int SLOPE_W   = 27;
    localparam int CMP_W     = 28;
    localparam int OUT_W     = 27;
    localparam int ONSET_W   = 16;

    // Output queue
    localparam int OUT_DEPTH = 16;
    localparam int OUT_AW    = 4;

    localparam logic [REG_W-1:0] AMP_RESET  = 26'd30;
    localparam logic [REG_W-1:0] RISE_RESET = 26'd20;

    typedef enum logic {
        REG_AMP  = 1'b0,
        REG_RISE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [REG_W-1:0] amp_thr;
        logic [REG_W-1:0] rise_thr;
    } thresh_t;

    typedef struct packed {
        logic                      valid;
        logic signed [BAND_W-1:0]  band;
        logic signed [DERIV_W-1:0] deriv;
    } deriv_item_t;

    typedef struct packed {
        logic                      valid;
        logic signed [BAND_W-1:0]  band;
        logic signed [INTEG_W-1:0] integ;
    } integ_item_t;

    typedef struct packed {
        logic [OUT_W-1:0]   band_value;
        logic [OUT_W-1:0]   integrated_value;
        logic               r_detected;
        logic [REG_W-1:0]   r_peak_value;
        logic [ONSET_W-1:0] onset_count;
    } result_t;

endpackage

// File: design/eqrs_filter_front.sv
module eqrs_filter_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic [eqrs_pkg::IN_W-1:0]   in_sample,
    output eqrs_pkg::deriv_item_t       out_item
);
    import eqrs_pkg::*;

    localparam int PAD = DATA_W - SAMPLE_BITS;

    typedef logic [SAMPLE_BITS-1:0] samp_t;

    // Low-pass state
    samp_t       lp_hist_reg [LP_TAPS];
    logic [31:0] lp_tap_reg;
    logic [31:0] y1_reg, y2_reg;
    logic [31:0] x_ext, y_next, tap_next;
    logic signed [LP_W-1:0] lp;

    // High-pass history memory and its bookkeeping
    logic signed [LP_W-1:0] hp_mem [HP_TAPS];
    logic [HP_AW-1:0]       wr_ptr_reg;
    logic [HP_AW:0]         fill_reg;
    logic signed [LP_W-1:0] rd_old_reg, rd_mid_reg;
    logic [31:0]            hsum_reg, hp_next;
    logic signed [LP_W-1:0] old_lp, mid_lp;

    // Stage registers
    logic                   s1_valid_reg, s1_old_ok_reg, s1_mid_ok_reg;
    logic signed [LP_W-1:0] s1_lp_reg;
    logic [HP_AW-1:0]       s1_addr_reg;
    logic                   s2_valid_reg;
    logic signed [LP_W-1:0] s2_hp_reg, s2_mid_reg;
    logic                   s3_valid_reg;
    logic signed [BAND_W-1:0] s3_band_reg;
    logic signed [BAND_W-1:0] band_next;
    logic signed [BAND_W-1:0] band_tap_reg [4];
    logic signed [DSUM_W-1:0] d_sum;

    assign x_ext    = {{PAD{1'b0}}, in_sample[SAMPLE_BITS-1:0]};
    assign y_next   = (y1_reg << 1) - y2_reg + x_ext + lp_tap_reg;
    assign lp       = $signed(y_next[DATA_W-1 -: LP_W]);
    // Next sample sees today's taps one place further down the line
    assign tap_next = {{PAD{1'b0}}, lp_hist_reg[LP_TAPS-2]}
                    - ({{PAD{1'b0}}, lp_hist_reg[LP_MID-2]} << 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LP_TAPS; i++) lp_hist_reg[i] <= '0;
            lp_tap_reg <= '0;
            y1_reg     <= '0;
            y2_reg     <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end else if (in_valid) begin
            lp_hist_reg[0] <= in_sample[SAMPLE_BITS-1:0];
            for (int i = 1; i < LP_TAPS; i++) lp_hist_reg[i] <= lp_hist_reg[i-1];
            lp_tap_reg <= tap_next;
            y2_reg     <= y1_reg;
            y1_reg     <= y_next;
            wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (fill_reg != (HP_AW+1)'(HP_TAPS)) fill_reg <= fill_reg + 1'b1;
        end
    end

    // Read the oldest and the delayed entry ahead of the write
    always_ff @(posedge aclk) begin
        if (in_valid) begin
            rd_old_reg <= hp_mem[wr_ptr_reg];
            rd_mid_reg <= hp_mem[wr_ptr_reg - HP_AW'(HP_DELAY)];
        end
        if (s1_valid_reg) hp_mem[s1_addr_reg] <= s1_lp_reg;
    end

    always_ff @(posedge aclk) begin
        s1_lp_reg     <= lp;
        s1_addr_reg   <= wr_ptr_reg;
        s1_old_ok_reg <= (fill_reg == (HP_AW+1)'(HP_TAPS));
        s1_mid_ok_reg <= (fill_reg >= (HP_AW+1)'(HP_DELAY));
        if (!aresetn) s1_valid_reg <= 1'b0;
        else          s1_valid_reg <= in_valid;
    end

    assign old_lp  = s1_old_ok_reg ? rd_old_reg : '0;
    assign mid_lp  = s1_mid_ok_reg ? rd_mid_reg : '0;
    assign hp_next = hsum_reg + 32'(s1_lp_reg) - 32'(old_lp);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hsum_reg     <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_valid_reg) hsum_reg <= hp_next;
            s2_valid_reg <= s1_valid_reg;
        end
        s2_hp_reg  <= $signed(hp_next[DATA_W-1 -: LP_W]);
        s2_mid_reg <= mid_lp;
    end

    assign band_next = BAND_W'(s2_mid_reg) - BAND_W'(s2_hp_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) s3_valid_reg <= 1'b0;
        else          s3_valid_reg <= s2_valid_reg;
        s3_band_reg <= band_next;
    end

    // Five-point derivative over the band taps
    assign d_sum = (DSUM_W'(s3_band_reg) <<< 1) + DSUM_W'(band_tap_reg[3])
                 - DSUM_W'(band_tap_reg[1]) - (DSUM_W'(band_tap_reg[0]) <<< 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) band_tap_reg[i] <= '0;
            out_item.valid <= 1'b0;
        end else begin
            if (s3_valid_reg) begin
                band_tap_reg[0] <= band_tap_reg[1];
                band_tap_reg[1] <= band_tap_reg[2];
                band_tap_reg[2] <= band_tap_reg[3];
                band_tap_reg[3] <= s3_band_reg;
            end
            out_item.valid <= s3_valid_reg;
        end
        out_item.band  <= s3_band_reg;
        out_item.deriv <= DERIV_W'(d_sum >>> 3);
    end

endmodule

// File: design/eqrs_window.sv
module eqrs_window (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  eqrs_pkg::deriv_item_t in_item,
    output eqrs_pkg::integ_item_t out_item
);
    import eqrs_pkg::*;

    logic signed [SQ_W-1:0]    win_mem [WIN_LEN];
    logic [WIN_AW-1:0]         widx_reg, rd_addr;
    logic [WIN_AW:0]           fill_reg;
    logic signed [SQ_W-1:0]    rd_reg, sq, old_sq;
    logic signed [TOTAL_W-1:0] total_reg, total_next;

    logic                      s5_valid_reg, s5_old_ok_reg;
    logic signed [BAND_W-1:0]  s5_band_reg;
    logic signed [SQ_W-1:0]    s5_sq_reg;
    logic [WIN_AW-1:0]         s5_addr_reg;

    // Square wraps at the low word of the product
    assign sq      = SQ_W'(in_item.deriv) * SQ_W'(in_item.deriv >>> 2);
    assign rd_addr = widx_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            widx_reg <= '0;
            fill_reg <= '0;
        end else if (in_item.valid) begin
            widx_reg <= rd_addr;
            if (fill_reg != (WIN_AW+1)'(WIN_LEN)) fill_reg <= fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_item.valid) rd_reg <= win_mem[rd_addr];
        if (s5_valid_reg)  win_mem[s5_addr_reg] <= s5_sq_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) s5_valid_reg <= 1'b0;
        else          s5_valid_reg <= in_item.valid;
        s5_band_reg   <= in_item.band;
        s5_sq_reg     <= sq;
        s5_addr_reg   <= rd_addr;
        s5_old_ok_reg <= (fill_reg == (WIN_AW+1)'(WIN_LEN));
    end

    assign old_sq     = s5_old_ok_reg ? rd_reg : '0;
    assign total_next = total_reg - TOTAL_W'(old_sq) + TOTAL_W'(s5_sq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg      <= '0;
            out_item.valid <= 1'b0;
        end else begin
            if (s5_valid_reg) total_reg <= total_next;
            out_item.valid <= s5_valid_reg;
        end
        out_item.band  <= s5_band_reg;
        out_item.integ <= total_next[TOTAL_W-1 -: INTEG_W];
    end

endmodule

// File: design/eqrs_peak_tracker.sv
module eqrs_peak_tracker #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  eqrs_pkg::thresh_t     thr,
    input  eqrs_pkg::integ_item_t in_item,
    output logic                  res_valid,
    output eqrs_pkg::result_t     res
);
    import eqrs_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [1:0] FALL_SET = 2'd2;
    localparam logic [1:0] FALL_MAX = 2'd3;

    logic signed [INTEG_W-1:0] slope_tap_reg [4];
    logic signed [SSUM_W-1:0]  s_sum;

    logic                      s7_valid_reg;
    logic signed [BAND_W-1:0]  s7_band_reg;
    logic signed [INTEG_W-1:0] s7_integ_reg;
    logic signed [SLOPE_W-1:0] s7_slope_reg;

    logic [REG_W-1:0]      peak_reg, peak_next, rep_reg, rep_next;
    logic [1:0]            fall_reg, fall_next;
    logic                  r_flag_reg, r_flag_next;
    logic                  restart_reg, restart_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  active, rising;

    assign s_sum = (SSUM_W'(in_item.integ) <<< 1) + SSUM_W'(slope_tap_reg[3])
                 - SSUM_W'(slope_tap_reg[1]) - (SSUM_W'(slope_tap_reg[0]) <<< 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) slope_tap_reg[i] <= '0;
            s7_valid_reg <= 1'b0;
        end else begin
            if (in_item.valid) begin
                slope_tap_reg[0] <= slope_tap_reg[1];
                slope_tap_reg[1] <= slope_tap_reg[2];
                slope_tap_reg[2] <= slope_tap_reg[3];
                slope_tap_reg[3] <= in_item.integ;
            end
            s7_valid_reg <= in_item.valid;
        end
        s7_band_reg  <= in_item.band;
        s7_integ_reg <= in_item.integ;
        s7_slope_reg <= SLOPE_W'(s_sum >>> 3);
    end

    assign active = CMP_W'(s7_integ_reg) > $signed({2'b00, thr.amp_thr});
    assign rising = CMP_W'(s7_slope_reg) > $signed({2'b00, thr.rise_thr});

    always_comb begin
        peak_next    = peak_reg;
        rep_next     = rep_reg;
        fall_next    = fall_reg;
        r_flag_next  = r_flag_reg;
        restart_next = restart_reg;
        cnt_next     = (cnt_reg != CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
        if (active) begin
            if (restart_reg) begin
                cnt_next     = '0;
                restart_next = 1'b0;
            end
            if (rising) begin
                if (CMP_W'(s7_integ_reg) > $signed({2'b00, peak_reg}))
                    peak_next = s7_integ_reg[REG_W-1:0];
            end else begin
                if (CMP_W'(s7_integ_reg) < $signed({2'b00, peak_reg})) begin
                    if (fall_reg != FALL_MAX) fall_next = fall_reg + 1'b1;
                    if (fall_next == FALL_SET)      r_flag_next = 1'b1;
                    else if (fall_next == FALL_MAX) r_flag_next = 1'b0;
                end
                rep_next = peak_reg;
            end
        end else begin
            peak_next = '0;
            rep_next  = '0;
            fall_next = '0;
            if (s7_slope_reg < 0) restart_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg    <= '0;
            rep_reg     <= '0;
            fall_reg    <= '0;
            r_flag_reg  <= 1'b0;
            restart_reg <= 1'b0;
            cnt_reg     <= '0;
        end else if (s7_valid_reg) begin
            peak_reg    <= peak_next;
            rep_reg     <= rep_next;
            fall_reg    <= fall_next;
            r_flag_reg  <= r_flag_next;
            restart_reg <= restart_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign res_valid            = s7_valid_reg;
    assign res.band_value       = s7_band_reg[OUT_W-1:0];
    assign res.integrated_value = s7_integ_reg;
    assign res.r_detected       = r_flag_next;
    assign res.r_peak_value     = rep_next;
    assign res.onset_count      = ONSET_W'(cnt_next);

    a_r_set_on_second_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s7_valid_reg && r_flag_next && !r_flag_reg) |-> (fall_next == FALL_SET))
        else $error("R flag set away from the second falling sample");

    a_quiet_clears_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        (s7_valid_reg && !active) |=> (peak_reg == '0 && fall_reg == '0))
        else $error("peak state not cleared in quiet region");

endmodule

// File: design/eqrs_out_fifo.sv
module eqrs_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    input  eqrs_pkg::result_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output eqrs_pkg::result_t rd_data
);
    import eqrs_pkg::*;

    result_t           buf_mem [OUT_DEPTH];
    logic [OUT_AW:0]   wp_reg, rp_reg;

    always_ff @(posedge aclk) begin
        if (wr_valid) buf_mem[wp_reg[OUT_AW-1:0]] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            if (wr_valid)             wp_reg <= wp_reg + 1'b1;
            if (rd_valid && rd_ready) rp_reg <= rp_reg + 1'b1;
        end
    end

    assign rd_valid = (wp_reg != rp_reg);
    assign rd_data  = buf_mem[rp_reg[OUT_AW-1:0]];

endmodule

// File: design/ecg_qrs_peak_detector_core.sv
// QRS peak detector for one ECG lead.
//
// Input channel (s_valid/s_ready): one unsigned sample per request. Output
// channel (m_valid/m_ready): one result per sample, in order, carrying the
// band-pass value, the window integral, the R flag, the tracked peak level
// and the onset counter. Thresholds sit on a small APB port: offset 0x0 is
// the amplitude threshold, 0x4 the rising-slope threshold; write them only
// while no request is outstanding.
//
// Throughput is one sample per cycle while s_ready is high. A result shows
// on m_valid once its sample has passed the seven-stage pipeline and been
// written to the output queue. The pipeline never stalls; the high-pass
// history and window memories are read through registers. Results land in
// a 16-entry output queue. s_ready stays high while fewer than 16 samples
// are in flight or queued, so a stalled receiver lets the input run on
// until the queue is full.
// Reset clears filters, taps and tracker state and sets the thresholds to 30 and 20.
// Both 32-entry memories keep their contents; fill counts mask entries not
// yet written, so the block is ready at once with no clearing pass.
module ecg_qrs_peak_detector_core #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [eqrs_pkg::IN_W-1:0]          s_ecg_sample,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [eqrs_pkg::OUT_W-1:0]  m_band_value,
    output logic signed [eqrs_pkg::OUT_W-1:0]  m_integrated_value,
    output logic                               m_r_detected,
    output logic [eqrs_pkg::REG_W-1:0]         m_r_peak_value,
    output logic [eqrs_pkg::ONSET_W-1:0]       m_onset_count,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [eqrs_pkg::ADDR_W-1:0]        paddr,
    input  logic [eqrs_pkg::DATA_W-1:0]        pwdata,
    output logic [eqrs_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import eqrs_pkg::*;

    localparam int RPAD = DATA_W - REG_W;

    logic [REG_W-1:0] amp_reg, rise_reg;
    thresh_t          thr;
    reg_idx_t         reg_sel;

    logic             in_acc, out_acc;
    logic [OUT_AW:0]  occ_reg;

    deriv_item_t      deriv_item;
    integ_item_t      integ_item;
    logic             res_valid;
    result_t          res, out_res;

    // Register file: write on the access phase, read back by address
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_reg  <= AMP_RESET;
            rise_reg <= RISE_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_AMP:  amp_reg  <= pwdata[REG_W-1:0];
                REG_RISE: rise_reg <= pwdata[REG_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_AMP:  prdata = {{RPAD{1'b0}}, amp_reg};
            REG_RISE: prdata = {{RPAD{1'b0}}, rise_reg};
            default:  prdata = '0;
        endcase
    end

    assign thr.amp_thr  = amp_reg;
    assign thr.rise_thr = rise_reg;

    // Count every request from acceptance until its result is taken; hold
    // s_ready low once the output queue could not absorb one more result.
    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;
    assign s_ready = (occ_reg != (OUT_AW+1)'(OUT_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            if (in_acc && !out_acc)      occ_reg <= occ_reg + 1'b1;
            else if (!in_acc && out_acc) occ_reg <= occ_reg - 1'b1;
        end
    end

    // Low-pass, high-pass and derivative
    eqrs_filter_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_acc),
        .in_sample (s_ecg_sample),
        .out_item  (deriv_item)
    );

    // Square and moving-window integral
    eqrs_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (deriv_item),
        .out_item (integ_item)
    );

    // Slope, peak tracking and onset counter
    eqrs_peak_tracker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .thr       (thr),
        .in_item   (integ_item),
        .res_valid (res_valid),
        .res       (res)
    );

    // Decouple the receiver from the pipeline
    eqrs_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (res_valid),
        .wr_data  (res),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_data  (out_res)
    );

    assign m_band_value       = $signed(out_res.band_value);
    assign m_integrated_value = $signed(out_res.integrated_value);
    assign m_r_detected       = out_res.r_detected;
    assign m_r_peak_value     = out_res.r_peak_value;
    assign m_onset_count      = out_res.onset_count;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= (OUT_AW+1)'(OUT_DEPTH))
        else $error("outstanding request count above queue depth");

    a_fixed_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |-> ##7 res_valid)
        else $error("accepted sample did not reach the output queue in time");

    a_valid_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (occ_reg != '0))
        else $error("result offered with no outstanding request");

endmodule
